// ===== design/bwmm_pkg.sv =====
// ----------------------------------------------------------------------------
// bwmm_pkg
// Shared types and sizes for the banked window min/max/mean block.
// ----------------------------------------------------------------------------
package bwmm_pkg;

   localparam int SLOTS_PER_BANK = 6;
   localparam int BANK_COUNT     = 3;
   localparam int AXES           = 3;

   localparam int SAMPLE_W = 16;
   localparam int BANK_W   = 2;
   localparam int CNT_W    = 3;

   localparam int ROW_COUNT  = BANK_COUNT * SLOTS_PER_BANK;
   localparam int ROW_W      = $clog2(ROW_COUNT);
   localparam int ROW_DATA_W = AXES * SAMPLE_W;

   // sum of up to SLOTS_PER_BANK signed samples, and its magnitude
   localparam int SUM_W = SAMPLE_W + $clog2(SLOTS_PER_BANK + 1);
   localparam int MAG_W = SUM_W - 1;

   // divider retires two quotient bits a cycle
   localparam int DIV_STEPS = (MAG_W + 1) / 2;
   localparam int QUO_W     = 2 * DIV_STEPS;
   localparam int REM_W     = CNT_W + 1;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic [BANK_W-1:0] bank;
      logic [CNT_W-1:0]  count;
      sample_type        x;
      sample_type        y;
      sample_type        z;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_LAST,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

// ===== design/bwmm_front.sv =====
// ----------------------------------------------------------------------------
// bwmm_front
// Request intake: handshake against the queue and clamp bank and slot count.
// ----------------------------------------------------------------------------
module bwmm_front (
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [bwmm_pkg::BANK_W-1:0] req_bank,
   input  logic [bwmm_pkg::CNT_W-1:0]  req_slot_count,
   input  bwmm_pkg::sample_type       req_sample_x,
   input  bwmm_pkg::sample_type       req_sample_y,
   input  bwmm_pkg::sample_type       req_sample_z,
   input  bwmm_pkg::queue_status_type q_status,
   output logic                       q_push,
   output bwmm_pkg::item_type         q_item
);

   localparam logic [bwmm_pkg::BANK_W-1:0] BANK_MAX =
      bwmm_pkg::BANK_W'(bwmm_pkg::BANK_COUNT - 1);
   localparam logic [bwmm_pkg::CNT_W-1:0] CNT_MAX =
      bwmm_pkg::CNT_W'(bwmm_pkg::SLOTS_PER_BANK);
   localparam logic [bwmm_pkg::CNT_W-1:0] CNT_MIN = bwmm_pkg::CNT_W'(1);

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

   always_comb begin
      q_item.bank  = (req_bank > BANK_MAX) ? BANK_MAX : req_bank;
      if (req_slot_count < CNT_MIN) begin
         q_item.count = CNT_MIN;
      end else if (req_slot_count > CNT_MAX) begin
         q_item.count = CNT_MAX;
      end else begin
         q_item.count = req_slot_count;
      end
      q_item.x = req_sample_x;
      q_item.y = req_sample_y;
      q_item.z = req_sample_z;
   end

endmodule

// ===== design/bwmm_queue.sv =====
// ----------------------------------------------------------------------------
// bwmm_queue
// Two-word queue between intake and the statistics engine.
// ----------------------------------------------------------------------------
module bwmm_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  bwmm_pkg::item_type         push_item,
   input  logic                       pop,
   output bwmm_pkg::item_type         pop_item,
   output bwmm_pkg::queue_status_type status
);

   bwmm_pkg::item_type entry_ff [bwmm_pkg::QUEUE_DEPTH];

   logic [bwmm_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bwmm_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bwmm_pkg::QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == bwmm_pkg::QPTR_W'(bwmm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + bwmm_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == bwmm_pkg::QPTR_W'(bwmm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + bwmm_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + bwmm_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - bwmm_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == bwmm_pkg::QCNT_W'(bwmm_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== design/bwmm_back.sv =====
// ----------------------------------------------------------------------------
// bwmm_back
// Statistics engine: store the sample, walk the bank, divide, hold result.
// ----------------------------------------------------------------------------
module bwmm_back (
   input  logic                       clock,
   input  logic                       reset,
   input  bwmm_pkg::queue_status_type q_status,
   input  bwmm_pkg::item_type         q_item,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output bwmm_pkg::sample_type       rsp_mean_x,
   output bwmm_pkg::sample_type       rsp_mean_y,
   output bwmm_pkg::sample_type       rsp_mean_z,
   output bwmm_pkg::sample_type       rsp_lowest_x,
   output bwmm_pkg::sample_type       rsp_lowest_y,
   output bwmm_pkg::sample_type       rsp_lowest_z,
   output bwmm_pkg::sample_type       rsp_highest_x,
   output bwmm_pkg::sample_type       rsp_highest_y,
   output bwmm_pkg::sample_type       rsp_highest_z
);

   localparam int AXES     = bwmm_pkg::AXES;
   localparam int SAMPLE_W = bwmm_pkg::SAMPLE_W;
   localparam int SUM_W    = bwmm_pkg::SUM_W;
   localparam int MAG_W    = bwmm_pkg::MAG_W;
   localparam int QUO_W    = bwmm_pkg::QUO_W;
   localparam int REM_W    = bwmm_pkg::REM_W;
   localparam int ROW_W    = bwmm_pkg::ROW_W;

   typedef struct packed {
      logic [QUO_W-1:0] quo;
      logic [REM_W-1:0] rem;
   } div_type;

   // two restoring steps; quotient bits shift in where dividend bits leave
   function automatic div_type div_two_steps(input div_type cur,
                                             input logic [REM_W-1:0] d);
      div_type          res;
      logic [REM_W-1:0] r;
      res = cur;
      for (int i = 0; i < 2; i++) begin
         r       = {res.rem[REM_W-2:0], res.quo[QUO_W-1]};
         res.quo = {res.quo[QUO_W-2:0], 1'b0};
         if (r >= d) begin
            r          = r - d;
            res.quo[0] = 1'b1;
         end
         res.rem = r;
      end
      return res;
   endfunction

   bwmm_pkg::state_type state_ff, state_in;

   bwmm_pkg::item_type             item_ff;
   logic [bwmm_pkg::CNT_W-1:0]     slot_ff;
   logic                           pend_ff;
   logic                           first_ff;
   logic [bwmm_pkg::STEP_W-1:0]    step_ff;

   logic [bwmm_pkg::ROW_DATA_W-1:0] mem [bwmm_pkg::ROW_COUNT];
   logic [bwmm_pkg::ROW_COUNT-1:0]  row_valid_ff;
   logic [bwmm_pkg::ROW_DATA_W-1:0] rd_data_ff;
   logic                            rd_vld_ff;

   logic signed [SUM_W-1:0]    sum_ff [AXES];
   bwmm_pkg::sample_type       lo_ff  [AXES];
   bwmm_pkg::sample_type       hi_ff  [AXES];
   div_type                    div_ff [AXES];
   logic                       neg_ff [AXES];

   logic signed [SUM_W-1:0]    sum_in [AXES];
   bwmm_pkg::sample_type       lo_in  [AXES];
   bwmm_pkg::sample_type       hi_in  [AXES];

   bwmm_pkg::sample_type       out_mean_ff [AXES];
   bwmm_pkg::sample_type       out_lo_ff   [AXES];
   bwmm_pkg::sample_type       out_hi_ff   [AXES];
   logic                       rsp_valid_ff;

   logic                       mem_we;
   logic                       mem_re;
   logic                       load_out;
   logic [ROW_W-1:0]           wr_row;
   logic [ROW_W-1:0]           rd_row;
   logic                       last_slot;
   logic [REM_W-1:0]           divisor;

   assign last_slot = (slot_ff == item_ff.count - bwmm_pkg::CNT_W'(1));
   assign divisor   = REM_W'(item_ff.count);
   assign wr_row    = ROW_W'(item_ff.bank) * ROW_W'(bwmm_pkg::SLOTS_PER_BANK)
                    + ROW_W'(item_ff.count - bwmm_pkg::CNT_W'(1));
   assign rd_row    = ROW_W'(item_ff.bank) * ROW_W'(bwmm_pkg::SLOTS_PER_BANK)
                    + ROW_W'(slot_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bwmm_pkg::ST_IDLE:  if (!q_status.empty) state_in = bwmm_pkg::ST_WRITE;
         bwmm_pkg::ST_WRITE: state_in = bwmm_pkg::ST_READ;
         bwmm_pkg::ST_READ:  if (last_slot) state_in = bwmm_pkg::ST_LAST;
         bwmm_pkg::ST_LAST:  state_in = bwmm_pkg::ST_DIV;
         bwmm_pkg::ST_DIV: begin
            if (step_ff == bwmm_pkg::STEP_W'(bwmm_pkg::DIV_STEPS - 1)) begin
               state_in = bwmm_pkg::ST_DONE;
            end
         end
         bwmm_pkg::ST_DONE:  if (!rsp_valid_ff || !rsp_stall) state_in = bwmm_pkg::ST_IDLE;
         default:            state_in = bwmm_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop    = 1'b0;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         bwmm_pkg::ST_IDLE:  q_pop    = !q_status.empty;
         bwmm_pkg::ST_WRITE: mem_we   = 1'b1;
         bwmm_pkg::ST_READ:  mem_re   = 1'b1;
         bwmm_pkg::ST_LAST:  ;
         bwmm_pkg::ST_DIV:   ;
         bwmm_pkg::ST_DONE:  load_out = !rsp_valid_ff || !rsp_stall;
         default:            ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bwmm_pkg::ST_IDLE;
         row_valid_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= mem_re;
         if (mem_we) begin
            row_valid_ff[wr_row] <= 1'b1;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // row store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_row] <= {item_ff.z, item_ff.y, item_ff.x};
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_row];
         rd_vld_ff  <= row_valid_ff[rd_row];
      end
   end

   // fold the returning slot into the running sum, minimum and maximum
   always_comb begin
      bwmm_pkg::sample_type v;
      for (int a = 0; a < AXES; a++) begin
         v = rd_vld_ff ? rd_data_ff[a*SAMPLE_W +: SAMPLE_W] : '0;
         if (first_ff) begin
            sum_in[a] = SUM_W'(v);
            lo_in[a]  = v;
            hi_in[a]  = v;
         end else begin
            sum_in[a] = sum_ff[a] + SUM_W'(v);
            lo_in[a]  = (v < lo_ff[a]) ? v : lo_ff[a];
            hi_in[a]  = (v > hi_ff[a]) ? v : hi_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
      end
      if (state_ff == bwmm_pkg::ST_WRITE) begin
         slot_ff <= '0;
      end else if (mem_re) begin
         slot_ff <= slot_ff + bwmm_pkg::CNT_W'(1);
      end
      if (mem_re) begin
         first_ff <= (slot_ff == '0);
      end
      if (state_ff == bwmm_pkg::ST_LAST) begin
         step_ff <= '0;
      end else if (state_ff == bwmm_pkg::ST_DIV) begin
         step_ff <= step_ff + bwmm_pkg::STEP_W'(1);
      end
      for (int a = 0; a < AXES; a++) begin
         if (pend_ff) begin
            sum_ff[a] <= sum_in[a];
            lo_ff[a]  <= lo_in[a];
            hi_ff[a]  <= hi_in[a];
         end
         if (state_ff == bwmm_pkg::ST_LAST) begin
            // divide the magnitude, restore the sign afterward
            neg_ff[a]     <= sum_in[a][SUM_W-1];
            div_ff[a].quo <= sum_in[a][SUM_W-1] ?
                             QUO_W'(MAG_W'(-sum_in[a])) : QUO_W'(MAG_W'(sum_in[a]));
            div_ff[a].rem <= '0;
         end else if (state_ff == bwmm_pkg::ST_DIV) begin
            div_ff[a] <= div_two_steps(div_ff[a], divisor);
         end
         if (load_out) begin
            out_mean_ff[a] <= neg_ff[a] ? SAMPLE_W'(-div_ff[a].quo) : SAMPLE_W'(div_ff[a].quo);
            out_lo_ff[a]   <= lo_ff[a];
            out_hi_ff[a]   <= hi_ff[a];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mean_x    = out_mean_ff[0];
   assign rsp_mean_y    = out_mean_ff[1];
   assign rsp_mean_z    = out_mean_ff[2];
   assign rsp_lowest_x  = out_lo_ff[0];
   assign rsp_lowest_y  = out_lo_ff[1];
   assign rsp_lowest_z  = out_lo_ff[2];
   assign rsp_highest_x = out_hi_ff[0];
   assign rsp_highest_y = out_hi_ff[1];
   assign rsp_highest_z = out_hi_ff[2];

   a_last_to_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == bwmm_pkg::ST_LAST |=> state_ff == bwmm_pkg::ST_DIV)
      else $error("walk end did not start the divide");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == bwmm_pkg::ST_READ |-> slot_ff < item_ff.count)
      else $error("slot walk ran past the count");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == bwmm_pkg::ST_DONE)
      else $error("result raised outside the done state");

   a_pend_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == bwmm_pkg::ST_LAST |-> pend_ff)
      else $error("last slot data missing at walk end");

endmodule

// ===== design/banked_window_min_max_mean_core.sv =====
// ----------------------------------------------------------------------------
// banked_window_min_max_mean_core
// Banked per-axis mean, minimum and maximum over stored acceleration samples.
// ----------------------------------------------------------------------------
// Request word: bank, slot count and one X/Y/Z sample. Bank is clamped to
// the last bank, count to 1..6. The sample lands in slot count-1 of the bank,
// then slots 0..count-1 are walked and one response word carries the mean
// (truncated toward zero), minimum and maximum of each axis.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. A two-word queue sits behind the request port, so req_stall rises
// only when the queue is full.
// Each word walks the engine in order: queue pop, store write, one store
// read per slot, walk end, the radix-4 divide and result load.
// Reset clears the queue, the engine and every row-valid bit, so all slots
// read as zero until written. A stalled response holds in the output
// register while the engine works on the next queued word.
// ----------------------------------------------------------------------------
module banked_window_min_max_mean_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [bwmm_pkg::BANK_W-1:0] req_bank,
   input  logic [bwmm_pkg::CNT_W-1:0]  req_slot_count,
   input  bwmm_pkg::sample_type        req_sample_x,
   input  bwmm_pkg::sample_type        req_sample_y,
   input  bwmm_pkg::sample_type        req_sample_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bwmm_pkg::sample_type        rsp_mean_x,
   output bwmm_pkg::sample_type        rsp_mean_y,
   output bwmm_pkg::sample_type        rsp_mean_z,
   output bwmm_pkg::sample_type        rsp_lowest_x,
   output bwmm_pkg::sample_type        rsp_lowest_y,
   output bwmm_pkg::sample_type        rsp_lowest_z,
   output bwmm_pkg::sample_type        rsp_highest_x,
   output bwmm_pkg::sample_type        rsp_highest_y,
   output bwmm_pkg::sample_type        rsp_highest_z
);

   bwmm_pkg::queue_status_type q_status;
   bwmm_pkg::item_type         push_item;
   bwmm_pkg::item_type         pop_item;
   logic                       q_push;
   logic                       q_pop;

   bwmm_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_bank       (req_bank),
      .req_slot_count (req_slot_count),
      .req_sample_x   (req_sample_x),
      .req_sample_y   (req_sample_y),
      .req_sample_z   (req_sample_z),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_item         (push_item)
   );

   bwmm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   bwmm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_item        (pop_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_mean_x    (rsp_mean_x),
      .rsp_mean_y    (rsp_mean_y),
      .rsp_mean_z    (rsp_mean_z),
      .rsp_lowest_x  (rsp_lowest_x),
      .rsp_lowest_y  (rsp_lowest_y),
      .rsp_lowest_z  (rsp_lowest_z),
      .rsp_highest_x (rsp_highest_x),
      .rsp_highest_y (rsp_highest_y),
      .rsp_highest_z (rsp_highest_z)
   );

endmodule

// ===== test/banked_window_min_max_mean_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_window_min_max_mean_core_tb
// Self-checking bench for the banked per-axis mean/min/max block.
// ----------------------------------------------------------------------------
// Request words are sent through the valid/stall port with random gaps. The
// response side stalls at random and once holds off long enough to back up
// the request queue. Every accepted request runs through a local copy of the
// bank store, and each response word is compared field by field with the
// oldest predicted statistics. Directed words cover the sample extremes,
// unwritten slots, clamped bank and count codes and truncation of negative
// means. Random words mostly fill banks slot by slot with random content.
// ----------------------------------------------------------------------------
module banked_window_min_max_mean_core_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 300;
   localparam int TAIL_CYCLES    = 40;

   typedef struct packed {
      logic [bwmm_pkg::AXES-1:0][bwmm_pkg::SAMPLE_W-1:0] mean;
      logic [bwmm_pkg::AXES-1:0][bwmm_pkg::SAMPLE_W-1:0] lowest;
      logic [bwmm_pkg::AXES-1:0][bwmm_pkg::SAMPLE_W-1:0] highest;
   } window_stats_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [bwmm_pkg::BANK_W-1:0] req_bank;
   logic [bwmm_pkg::CNT_W-1:0]  req_slot_count;
   bwmm_pkg::sample_type        req_sample_x;
   bwmm_pkg::sample_type        req_sample_y;
   bwmm_pkg::sample_type        req_sample_z;
   logic                        rsp_valid;
   logic                        rsp_stall;
   bwmm_pkg::sample_type        rsp_mean_x;
   bwmm_pkg::sample_type        rsp_mean_y;
   bwmm_pkg::sample_type        rsp_mean_z;
   bwmm_pkg::sample_type        rsp_lowest_x;
   bwmm_pkg::sample_type        rsp_lowest_y;
   bwmm_pkg::sample_type        rsp_lowest_z;
   bwmm_pkg::sample_type        rsp_highest_x;
   bwmm_pkg::sample_type        rsp_highest_y;
   bwmm_pkg::sample_type        rsp_highest_z;

   bwmm_pkg::sample_type        sample_bank_store [bwmm_pkg::BANK_COUNT]
                                                  [bwmm_pkg::SLOTS_PER_BANK]
                                                  [bwmm_pkg::AXES];
   window_stats_type            pending_stats [$];
   string                       axis_tag [bwmm_pkg::AXES] = '{"x", "y", "z"};
   int                          fail_count = 0;
   int                          idle_cycles = 0;
   int                          hold_left = 0;
   bit                          sender_calm = 1'b0;
   bit                          receiver_calm = 1'b0;

   banked_window_min_max_mean_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_bank       (req_bank),
      .req_slot_count (req_slot_count),
      .req_sample_x   (req_sample_x),
      .req_sample_y   (req_sample_y),
      .req_sample_z   (req_sample_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mean_x     (rsp_mean_x),
      .rsp_mean_y     (rsp_mean_y),
      .rsp_mean_z     (rsp_mean_z),
      .rsp_lowest_x   (rsp_lowest_x),
      .rsp_lowest_y   (rsp_lowest_y),
      .rsp_lowest_z   (rsp_lowest_z),
      .rsp_highest_x  (rsp_highest_x),
      .rsp_highest_y  (rsp_highest_y),
      .rsp_highest_z  (rsp_highest_z)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Write the sample into the local store, then walk the bank like the block.
   function automatic window_stats_type compute_window_stats(
         input logic [bwmm_pkg::BANK_W-1:0] bank,
         input logic [bwmm_pkg::CNT_W-1:0]  count,
         input bwmm_pkg::sample_type        x,
         input bwmm_pkg::sample_type        y,
         input bwmm_pkg::sample_type        z);
      window_stats_type     stats;
      bwmm_pkg::sample_type incoming [bwmm_pkg::AXES];
      int                   b;
      int                   n;
      int                   acc;
      int                   lo;
      int                   hi;
      int                   v;
      b = (int'(bank) > bwmm_pkg::BANK_COUNT - 1) ? bwmm_pkg::BANK_COUNT - 1 : int'(bank);
      n = int'(count);
      if (n < 1) n = 1;
      if (n > bwmm_pkg::SLOTS_PER_BANK) n = bwmm_pkg::SLOTS_PER_BANK;
      incoming[0] = x;
      incoming[1] = y;
      incoming[2] = z;
      for (int a = 0; a < bwmm_pkg::AXES; a++) sample_bank_store[b][n-1][a] = incoming[a];
      for (int a = 0; a < bwmm_pkg::AXES; a++) begin
         acc = int'(sample_bank_store[b][0][a]);
         lo  = acc;
         hi  = acc;
         for (int s = 1; s < n; s++) begin
            v   = int'(sample_bank_store[b][s][a]);
            acc = acc + v;
            if (v < lo) lo = v;
            if (v > hi) hi = v;
         end
         stats.mean[a]    = 16'(acc / n);
         stats.lowest[a]  = 16'(lo);
         stats.highest[a] = 16'(hi);
      end
      return stats;
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic bwmm_pkg::sample_type pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'($signed($urandom_range(0, 16)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic [bwmm_pkg::BANK_W-1:0] bank,
                              input logic [bwmm_pkg::CNT_W-1:0]  count,
                              input bwmm_pkg::sample_type x, input bwmm_pkg::sample_type y,
                              input bwmm_pkg::sample_type z);
      int gap;
      req_valid      <= 1'b1;
      req_bank       <= bank;
      req_slot_count <= count;
      req_sample_x   <= x;
      req_sample_y   <= y;
      req_sample_z   <= z;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_stats.push_back(compute_window_stats(bank, count, x, y, z));
      gap = sender_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait for every predicted word to come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_edges();
      // unwritten slots read as zero
      send_sample(2'd0, 3'd6, 16'sd1, -16'sd1, 16'sh7fff);
      send_sample(2'd0, 3'd1, 16'sh8000, 16'sh7fff, 16'sd0);
      send_sample(2'd0, 3'd6, 16'sh7fff, 16'sh8000, 16'sd5);
      // negative means truncate toward zero
      send_sample(2'd1, 3'd1, -16'sd3, 16'sd3, -16'sd7);
      send_sample(2'd1, 3'd2, -16'sd2, 16'sd2, 16'sd0);
      send_sample(2'd1, 3'd3, -16'sd1, 16'sd1, -16'sd1);
      // bank 3 clamps to the last bank, count 7 clamps to a full bank
      send_sample(2'd3, 3'd7, 16'sh7fff, 16'sh8000, 16'sh7fff);
      for (int c = 1; c <= 5; c++)
         send_sample(2'd2, 3'(c), 16'sh7fff, 16'sh8000, (c % 2) ? 16'sh7fff : 16'sh8000);
      send_sample(2'd2, 3'd6, 16'sh7fff, 16'sh8000, 16'sh8000);
      // count 0 acts as count 1
      send_sample(2'd2, 3'd0, 16'sh8000, 16'sh7fff, 16'sd0);
      send_sample(2'd2, 3'd6, 16'sh7fff, 16'sh8000, 16'sh7fff);
      send_sample(2'd1, 3'd4, 16'sh5555, 16'shaaaa, 16'sh5555);
      send_sample(2'd0, 3'd5, 16'shaaaa, 16'sh5555, 16'shaaaa);
      send_sample(2'd3, 3'd0, 16'shffff, 16'sh0001, 16'sh8001);
      send_sample(2'd1, 3'd6, 16'sh8000, 16'sh8000, 16'sh8000);
      drain_responses();
   endtask

   task automatic test_random_traffic(input int word_total);
      int                          sent;
      int                          r;
      logic [bwmm_pkg::BANK_W-1:0] bank;
      logic [bwmm_pkg::CNT_W-1:0]  count;
      sent = 0;
      while (sent < word_total) begin
         r = $urandom_range(0, 99);
         bank = ($urandom_range(0, 29) == 0) ? 2'd3 :
                2'($urandom_range(0, bwmm_pkg::BANK_COUNT - 1));
         if (r < 40) begin
            // fill one bank slot by slot
            for (int c = 1; c <= bwmm_pkg::SLOTS_PER_BANK; c++) begin
               send_sample(bank, 3'(c), pick_sample(), pick_sample(), pick_sample());
               sent++;
            end
         end else begin
            if (r < 46) count = ($urandom_range(0, 1) != 0) ? 3'd7 : 3'd0;
            else count = 3'($urandom_range(1, bwmm_pkg::SLOTS_PER_BANK));
            send_sample(bank, count, pick_sample(), pick_sample(), pick_sample());
            sent++;
         end
      end
      drain_responses();
   endtask

   task automatic test_back_to_back();
      sender_calm   = 1'b1;
      receiver_calm = 1'b1;
      test_random_traffic(200);
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;
   endtask

   // Hold the response side while requests keep coming, so the queue fills.
   task automatic test_backlog_pressure();
      sender_calm = 1'b1;
      hold_left   = LONG_HOLD;
      for (int i = 0; i < 12; i++)
         send_sample(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                     pick_sample(), pick_sample(), pick_sample());
      sender_calm = 1'b0;
      drain_responses();
   endtask

   initial begin : response_sink
      int stall_left;
      int free_left;
      stall_left = 0;
      free_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (!receiver_calm) begin
               if (free_left > 0) begin
                  free_left--;
               end else begin
                  stall_left = pick_gap();
                  free_left  = $urandom_range(0, 6);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : response_check
      window_stats_type want;
      window_stats_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.mean    = {rsp_mean_z, rsp_mean_y, rsp_mean_x};
         got.lowest  = {rsp_lowest_z, rsp_lowest_y, rsp_lowest_x};
         got.highest = {rsp_highest_z, rsp_highest_y, rsp_highest_x};
         if (pending_stats.size() == 0) begin
            $error("response word with no request outstanding");
            fail_count++;
         end else begin
            want = pending_stats.pop_front();
            for (int a = 0; a < bwmm_pkg::AXES; a++) begin
               if (got.mean[a] !== want.mean[a]) begin
                  $error("mean_%s: expected %0d, actual %0d", axis_tag[a],
                         $signed(want.mean[a]), $signed(got.mean[a]));
                  fail_count++;
               end
               if (got.lowest[a] !== want.lowest[a]) begin
                  $error("lowest_%s: expected %0d, actual %0d", axis_tag[a],
                         $signed(want.lowest[a]), $signed(got.lowest[a]));
                  fail_count++;
               end
               if (got.highest[a] !== want.highest[a]) begin
                  $error("highest_%s: expected %0d, actual %0d", axis_tag[a],
                         $signed(want.highest[a]), $signed(got.highest[a]));
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("banked_window_min_max_mean_core test failed");
         $finish;
      end
   end

   initial begin
      for (int b = 0; b < bwmm_pkg::BANK_COUNT; b++)
         for (int s = 0; s < bwmm_pkg::SLOTS_PER_BANK; s++)
            for (int a = 0; a < bwmm_pkg::AXES; a++)
               sample_bank_store[b][s][a] = '0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_bank       = '0;
      req_slot_count = '0;
      req_sample_x   = '0;
      req_sample_y   = '0;
      req_sample_z   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_directed_edges();
      test_random_traffic(500);
      test_backlog_pressure();
      test_back_to_back();
      test_random_traffic(660);

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("banked_window_min_max_mean_core test passed");
      else
         $display("banked_window_min_max_mean_core test failed");
      $finish;
   end

endmodule

// ===== banked_window_min_max_mean_core.f =====
design/bwmm_pkg.sv
design/bwmm_front.sv
design/bwmm_queue.sv
design/bwmm_back.sv
design/banked_window_min_max_mean_core.sv
test/banked_window_min_max_mean_core_tb.sv
